// ===== rtl/core/wmdp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmdp_pkg
// Types and constants shared by the windowed minimum chain cells and top level.
// ----------------------------------------------------------------------------
package wmdp_pkg;

	localparam int COST_W = 48;
	localparam int AGE_W  = 7;
	localparam int GAP_W  = 6;
	localparam int IN_W   = 32;

	localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};
	localparam logic signed [COST_W-1:0] COST_MAX = {1'b0, {(COST_W-1){1'b1}}};
	localparam logic signed [COST_W-1:0] COST_MIN = {1'b1, {(COST_W-1){1'b0}}};

	localparam logic [1:0] CELL_HOLD   = 2'd0;
	localparam logic [1:0] CELL_AGE    = 2'd1;
	localparam logic [1:0] CELL_SHIFT  = 2'd2;
	localparam logic [1:0] CELL_UPDATE = 2'd3;

	typedef struct packed {
		logic                     valid;
		logic [AGE_W-1:0]         age;
		logic signed [COST_W-1:0] cost;
	} wmdp_entry_t;

	typedef struct packed {
		logic [1:0]               op;
		logic                     first;
		logic                     forced;
		logic                     full;
		logic signed [COST_W-1:0] best;
	} wmdp_ctrl_t;

endpackage

// ===== rtl/core/window_min_dp_forced_points.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_min_dp_forced_points
// Streaming windowed minimum-cost chain with forced points.
// ----------------------------------------------------------------------------
// Each accepted position gives one best_cost result. An item first ages the
// window, then adds the cost to the front candidate and prunes the window in
// all cells at once. Every candidate that leaves from the front adds a shift
// step, as the chain of cells shifts by one slot per cycle. With a steady
// max_gap at most one candidate leaves per item. After max_gap is lowered,
// more than one candidate can leave before the next update. A stalled output
// holds the update until the previous result has been taken. A new item is
// taken once the previous one has been written to the output register.
module window_min_dp_forced_points #(
	parameter int WINDOW = 63
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [31:0]            cost,
	input  logic                          forced,
	input  logic                          first,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [47:0]            best_cost,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [5:0]                    cfg_data
);
	import wmdp_pkg::*;

	localparam int DEPTH = WINDOW + 1;
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic                     state_q;
	logic [GAP_W-1:0]         max_gap_q;
	logic signed [IN_W-1:0]   cost_q;
	logic                     forced_q;
	logic                     out_valid_q;
	logic signed [COST_W-1:0] best_cost_q;

	wmdp_entry_t ents [DEPTH];
	logic        keeps [DEPTH];
	wmdp_entry_t last_next;
	wmdp_ctrl_t  ctrl;

	logic [GAP_W-1:0]         gap_lo;
	logic [GAP_W-1:0]         gap;
	logic                     expired;
	logic                     out_free;
	logic                     in_xfer;
	logic signed [COST_W-1:0] front_cost;
	logic signed [COST_W:0]   sum;
	logic signed [COST_W-1:0] best;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign best_cost = best_cost_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign gap_lo = (max_gap_q == '0) ? GAP_W'(1) : max_gap_q;
	assign gap = ({2'b00, gap_lo} > 8'(WINDOW)) ? GAP_W'(WINDOW) : gap_lo;
	assign expired = ents[0].valid && (ents[0].age > {1'b0, gap});

	assign front_cost = ents[0].valid ? ents[0].cost : '0;
	assign sum = {front_cost[COST_W-1], front_cost} + (COST_W+1)'(cost_q);
	always_comb begin
		if (sum[COST_W] != sum[COST_W-1]) begin
			best = sum[COST_W] ? COST_MIN : COST_MAX;
		end else begin
			best = sum[COST_W-1:0];
		end
	end

	always_comb begin
		ctrl.op     = CELL_HOLD;
		ctrl.first  = first;
		ctrl.forced = forced_q;
		ctrl.full   = keeps[DEPTH-1];
		ctrl.best   = best;
		if (state_q == ST_IDLE) begin
			if (in_xfer) begin
				ctrl.op = CELL_AGE;
			end
		end else if (expired) begin
			ctrl.op = CELL_SHIFT;
		end else if (out_free) begin
			ctrl.op = CELL_UPDATE;
		end
	end

	always_comb begin
		last_next.valid = (ctrl.op == CELL_UPDATE);
		last_next.age   = '0;
		last_next.cost  = best;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		wmdp_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.head      (i == 0),
			.ctrl      (ctrl),
			.next_ent  ((i == DEPTH - 1) ? last_next : ents[(i + 1) % DEPTH]),
			.prev_keep ((i == 0) ? 1'b1 : keeps[(i + DEPTH - 1) % DEPTH]),
			.ent       (ents[i]),
			.keep      (keeps[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			max_gap_q   <= GAP_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_gap_q <= cfg_data;
			end
			if (ctrl.op == CELL_UPDATE) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (ctrl.op == CELL_UPDATE) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cost_q   <= cost;
			forced_q <= forced;
		end
		if (ctrl.op == CELL_UPDATE) begin
			best_cost_q <= best;
		end
	end

endmodule

// ===== rtl/core/wmdp_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmdp_cell
// One window slot: holds a candidate and shifts, ages or replaces it on command.
// ----------------------------------------------------------------------------
module wmdp_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head,
	input  wmdp_pkg::wmdp_ctrl_t  ctrl,
	input  wmdp_pkg::wmdp_entry_t next_ent,
	input  logic                 prev_keep,
	output wmdp_pkg::wmdp_entry_t ent,
	output logic                 keep
);
	import wmdp_pkg::*;

	wmdp_entry_t ent_q;
	logic        place;

	assign ent   = ent_q;
	assign keep  = ent_q.valid && !ctrl.forced && (ent_q.cost < ctrl.best);
	assign place = !keep && prev_keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q.valid <= head;
			ent_q.age   <= '0;
			ent_q.cost  <= '0;
		end else begin
			case (ctrl.op)
				CELL_AGE: begin
					if (ctrl.first) begin
						ent_q.valid <= head;
						ent_q.age   <= AGE_W'(head);
						ent_q.cost  <= '0;
					end else if (ent_q.valid && ent_q.age != AGE_MAX) begin
						ent_q.age <= ent_q.age + AGE_W'(1);
					end
				end
				CELL_SHIFT: begin
					ent_q <= next_ent;
				end
				CELL_UPDATE: begin
					if (ctrl.full) begin
						ent_q <= next_ent;
					end else if (!keep) begin
						ent_q.valid <= place;
						ent_q.age   <= '0;
						ent_q.cost  <= ctrl.best;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/wmdp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmdp_checker
// Port-level checks on transfer ordering of the windowed minimum chain block.
// ----------------------------------------------------------------------------
module wmdp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [47:0] best_cost
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(best_cost))
		else $error("Stalled result changed or dropped.");

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("Input taken again right after a transfer.");

	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("Result appeared while the block was idle.");

endmodule

bind window_min_dp_forced_points wmdp_checker u_wmdp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.best_cost (best_cost)
);

// ===== test/window_min_dp_forced_points_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_min_dp_forced_points_test
// Self-checking testbench for the windowed minimum-cost chain.
// ----------------------------------------------------------------------------
// A table of directed positions runs first, covering restarts, forced points,
// cost extremes and the gap limits. Random phases with different max_gap
// settings follow. Every input transfer feeds a behavioral window model;
// each result is checked against the oldest pending value, from the table for
// checked rows. Both sides idle and stall at random in all but calm phases.
// ----------------------------------------------------------------------------
module window_min_dp_forced_points_test;

	import wmdp_pkg::*;

	localparam int WINDOW = 63;

	typedef enum logic {ROW_ITEM, ROW_GAP} row_kind_t;

	typedef struct packed {
		row_kind_t                kind;
		logic signed [IN_W-1:0]   c;
		logic                     f;
		logic                     s;
		logic                     chk;
		logic signed [COST_W-1:0] want;
	} stim_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic signed [IN_W-1:0]   cost;
	logic                     forced;
	logic                     first;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [COST_W-1:0] best_cost;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [GAP_W-1:0]         cfg_data;

	logic signed [COST_W-1:0] best_due[$];
	logic signed [COST_W-1:0] win_cost[$];
	logic [AGE_W-1:0]         win_age[$];
	logic [GAP_W-1:0]         gap_reg;
	bit                       calm;
	int unsigned              fail_count;

	stim_row_t dir_rows [0:24] = '{
		'{ROW_ITEM, 32'sd5, 1'b0, 1'b0, 1'b1, 48'sd5},
		'{ROW_ITEM, 32'sh7fffffff, 1'b0, 1'b1, 1'b1, 48'sd2147483647},
		'{ROW_ITEM, 32'sh80000000, 1'b0, 1'b1, 1'b1, -48'sd2147483648},
		'{ROW_ITEM, -32'sd1, 1'b1, 1'b1, 1'b1, -48'sd1},
		'{ROW_ITEM, 32'sd0, 1'b0, 1'b1, 1'b1, 48'sd0},
		'{ROW_ITEM, 32'sd10, 1'b0, 1'b0, 1'b0, 48'sd0},
		'{ROW_ITEM, -32'sd3, 1'b1, 1'b0, 1'b0, 48'sd0},
		'{ROW_ITEM, 32'sh7fffffff, 1'b0, 1'b0, 1'b0, 48'sd0},
		'{ROW_GAP, 32'sd63, 1'b0, 1'b0, 1'b0, 48'sd0},
		'{ROW_ITEM, 32'sd0, 1'b0, 1'b1, 1'b1, 48'sd0},
		'{ROW_ITEM, 32'sd1, 1'b0, 1'b0, 1'b0, 48'sd0},
		'{ROW_ITEM, 32'sd2, 1'b0, 1'b0, 1'b0, 48'sd0},
		'{ROW_ITEM, 32'sd4, 1'b0, 1'b0, 1'b0, 48'sd0},
		'{ROW_ITEM, 32'sd8, 1'b0, 1'b0, 1'b0, 48'sd0},
		'{ROW_ITEM, 32'sd100, 1'b1, 1'b0, 1'b0, 48'sd0},
		'{ROW_ITEM, 32'sh80000000, 1'b0, 1'b0, 1'b0, 48'sd0},
		'{ROW_ITEM, 32'sd3, 1'b0, 1'b0, 1'b0, 48'sd0},
		'{ROW_GAP, 32'sd0, 1'b0, 1'b0, 1'b0, 48'sd0},
		'{ROW_ITEM, 32'sd7, 1'b0, 1'b0, 1'b0, 48'sd0},
		'{ROW_ITEM, -32'sd7, 1'b0, 1'b1, 1'b1, -48'sd7},
		'{ROW_ITEM, 32'sh7fffffff, 1'b1, 1'b0, 1'b0, 48'sd0},
		'{ROW_GAP, 32'sd2, 1'b0, 1'b0, 1'b0, 48'sd0},
		'{ROW_ITEM, 32'sd1, 1'b0, 1'b1, 1'b1, 48'sd1},
		'{ROW_ITEM, 32'sd5, 1'b0, 1'b0, 1'b0, 48'sd0},
		'{ROW_ITEM, -32'sd2, 1'b0, 1'b0, 1'b0, 48'sd0}
	};

	logic [GAP_W-1:0] phase_gap [0:9] = '{6'd63, 6'd0, 6'd1, 6'd2, 6'd63, 6'd5, 6'd40, 6'd1,
		6'd63, 6'd12};

	window_min_dp_forced_points #(
		.WINDOW(WINDOW)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cost(cost),
		.forced(forced),
		.first(first),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.best_cost(best_cost),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#80_000_000;
		$display("[window_min_dp_forced_points] ERROR");
		$finish;
	end

	function automatic int unsigned pause_len();
		return calm ? 0 : $urandom_range(0, 11);
	endfunction

	function automatic logic signed [COST_W-1:0] chain_best(input logic signed [IN_W-1:0] c,
			input logic f, input logic s);
		int unsigned g;
		longint sum;
		logic signed [COST_W-1:0] best;
		g = (gap_reg == 0) ? 1 : gap_reg;
		if (g > WINDOW) g = WINDOW;
		if (s) begin
			win_cost.delete();
			win_age.delete();
			win_cost.insert(win_cost.size(), '0);
			win_age.insert(win_age.size(), '0);
		end
		foreach (win_age[i])
			if (win_age[i] != AGE_MAX) win_age[i] = win_age[i] + 1'b1;
		while (win_age.size() > 0 && win_age[0] > g) begin
			win_cost.delete(0);
			win_age.delete(0);
		end
		sum = ((win_cost.size() > 0) ? longint'(win_cost[0]) : 64'sd0) + longint'(c);
		if (sum > longint'(COST_MAX)) best = COST_MAX;
		else if (sum < longint'(COST_MIN)) best = COST_MIN;
		else best = sum[COST_W-1:0];
		if (f) begin
			win_cost.delete();
			win_age.delete();
		end
		while (win_cost.size() > 0 && win_cost[$] >= best) begin
			win_cost.delete(win_cost.size() - 1);
			win_age.delete(win_age.size() - 1);
		end
		if (win_cost.size() >= WINDOW + 1) begin
			win_cost.delete(0);
			win_age.delete(0);
		end
		win_cost.insert(win_cost.size(), best);
		win_age.insert(win_age.size(), '0);
		return best;
	endfunction

	function automatic logic signed [IN_W-1:0] cost_pick();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return $urandom_range(0, 1000);
		if (r < 70) return 32'sd0 - $urandom_range(1, 1000);
		if (r < 90) return $urandom;
		case ($urandom_range(0, 3))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'sd0;
			default: return -32'sd1;
		endcase
	endfunction

	task automatic send_position(input logic signed [IN_W-1:0] c, input logic f, input logic s,
			input logic chk, input logic signed [COST_W-1:0] want);
		int unsigned hold;
		logic signed [COST_W-1:0] pred;
		hold = pause_len();
		if (hold != 0) begin
			in_valid <= 1'b0;
			repeat (hold) @(posedge clk);
		end
		in_valid <= 1'b1;
		cost <= c;
		forced <= f;
		first <= s;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		pred = chain_best(c, f, s);
		best_due.insert(best_due.size(), chk ? want : pred);
	endtask

	task automatic await_results();
		in_valid <= 1'b0;
		while (best_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_max_gap(input logic [GAP_W-1:0] g);
		await_results();
		cfg_valid <= 1'b1;
		cfg_data <= g;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		cfg_valid <= 1'b0;
		gap_reg = g;
	endtask

	initial begin
		int unsigned n;
		in_valid <= 1'b0;
		cost <= '0;
		forced <= 1'b0;
		first <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		calm = 1'b0;
		fail_count = 0;
		gap_reg = 6'd1;
		win_cost.insert(win_cost.size(), '0);
		win_age.insert(win_age.size(), '0);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_GAP)
				load_max_gap(dir_rows[i].c[GAP_W-1:0]);
			else
				send_position(dir_rows[i].c, dir_rows[i].f, dir_rows[i].s, dir_rows[i].chk,
					dir_rows[i].want);
		end

		for (int p = 0; p < 10; p++) begin
			load_max_gap((p >= 8) ? GAP_W'($urandom_range(0, 63)) : phase_gap[p]);
			calm = (p % 4 == 3);
			for (n = 0; n < 170; n++) begin
				send_position(cost_pick(), $urandom_range(0, 9) == 0,
					(n == 0) || ($urandom_range(0, 24) == 0), 1'b0, '0);
				if ($urandom_range(0, 49) == 0) await_results();
			end
		end

		in_valid <= 1'b0;
		while (best_due.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0 && best_due.size() == 0) begin
			$display("[window_min_dp_forced_points] OK");
		end else begin
			$display("[window_min_dp_forced_points] ERROR");
		end
		$finish;
	end

	initial begin
		int unsigned hold;
		logic signed [COST_W-1:0] want;
		forever begin
			hold = pause_len();
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (out_valid !== 1'b1) @(posedge clk);
			if (best_due.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("result transfer with nothing pending: best_cost=%0d", best_cost);
			end else begin
				want = best_due[0];
				best_due.delete(0);
				if (best_cost !== want) begin
					fail_count++;
					if (fail_count <= 10)
						$display("best_cost mismatch: expected %0d, got %0d", want, best_cost);
				end
			end
		end
	end

endmodule
